FILE: rtl/core/fbcm_pkg.sv
package fbcm_pkg;

	localparam int BLOCK_W        = 10;
	localparam int STAT_W         = 2;
	localparam int CMD_W          = 2;
	localparam int UPC_W          = 4;
	localparam int DEF_NUM_BLOCKS = 1024;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNLINK = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd2;

	// microprogram entry points and steps
	localparam logic [UPC_W-1:0] UA_A0  = 4'd0;
	localparam logic [UPC_W-1:0] UA_A1  = 4'd1;
	localparam logic [UPC_W-1:0] UA_A2  = 4'd2;
	localparam logic [UPC_W-1:0] UA_U0  = 4'd3;
	localparam logic [UPC_W-1:0] UA_U1  = 4'd4;
	localparam logic [UPC_W-1:0] UA_R1  = 4'd5;
	localparam logic [UPC_W-1:0] UA_L0  = 4'd6;
	localparam logic [UPC_W-1:0] UA_INV = 4'd7;
	localparam logic [UPC_W-1:0] UA_EMP = 4'd8;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_RD_FLAG,
		ACT_APP_WR,
		ACT_APP_LINK,
		ACT_RD_LINKS_BLK,
		ACT_RD_LINKS_HEAD,
		ACT_REMOVE
	} act_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_BAD_APP,
		COND_BAD_UNL,
		COND_EMPTY
	} cond_t;

	typedef struct packed {
		act_t              act;
		cond_t             cond;
		logic              wait_out;
		logic              last;
		logic [STAT_W-1:0] status;
		logic [UPC_W-1:0]  t_addr;
		logic [UPC_W-1:0]  f_addr;
	} ucode_t;

	typedef struct packed {
		logic bad_app;
		logic bad_unl;
		logic empty;
	} cond_flags_t;

	typedef struct packed {
		logic busy;
		logic step;
		logic hit;
	} seq_status_t;

	function automatic ucode_t uword(act_t a, cond_t c, logic w, logic l,
		logic [STAT_W-1:0] s, logic [UPC_W-1:0] t, logic [UPC_W-1:0] f);
		ucode_t u;
		u.act      = a;
		u.cond     = c;
		u.wait_out = w;
		u.last     = l;
		u.status   = s;
		u.t_addr   = t;
		u.f_addr   = f;
		return u;
	endfunction

	// control store: act fires only when the step's condition is false
	function automatic ucode_t ucode_rom(logic [UPC_W-1:0] upc);
		ucode_t u;
		unique case (upc)
			UA_A0:   u = uword(ACT_RD_FLAG, COND_NONE, 1'b1, 1'b0, STATUS_DONE,
				UA_A1, UA_A1);
			UA_A1:   u = uword(ACT_APP_WR, COND_BAD_APP, 1'b0, 1'b0, STATUS_DONE,
				UA_INV, UA_A2);
			UA_A2:   u = uword(ACT_APP_LINK, COND_NONE, 1'b0, 1'b1, STATUS_DONE,
				UA_A0, UA_A0);
			UA_U0:   u = uword(ACT_RD_FLAG, COND_NONE, 1'b1, 1'b0, STATUS_DONE,
				UA_U1, UA_U1);
			UA_U1:   u = uword(ACT_RD_LINKS_BLK, COND_BAD_UNL, 1'b0, 1'b0, STATUS_DONE,
				UA_INV, UA_R1);
			UA_R1:   u = uword(ACT_REMOVE, COND_NONE, 1'b0, 1'b1, STATUS_DONE,
				UA_A0, UA_A0);
			UA_L0:   u = uword(ACT_RD_LINKS_HEAD, COND_EMPTY, 1'b1, 1'b0, STATUS_DONE,
				UA_EMP, UA_R1);
			UA_INV:  u = uword(ACT_NONE, COND_NONE, 1'b1, 1'b1, STATUS_INVALID,
				UA_A0, UA_A0);
			UA_EMP:  u = uword(ACT_NONE, COND_NONE, 1'b0, 1'b1, STATUS_EMPTY,
				UA_A0, UA_A0);
			default: u = uword(ACT_NONE, COND_NONE, 1'b1, 1'b1, STATUS_INVALID,
				UA_A0, UA_A0);
		endcase
		return u;
	endfunction

	function automatic logic [UPC_W-1:0] dispatch(logic [CMD_W-1:0] cmd);
		logic [UPC_W-1:0] a;
		unique case (cmd)
			CMD_APPEND: a = UA_A0;
			CMD_ALLOC:  a = UA_L0;
			CMD_UNLINK: a = UA_U0;
			default:    a = UA_INV;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/core/fbcm_ram.sv
module fbcm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: rtl/core/fbcm_seq.sv
module fbcm_seq import fbcm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CMD_W-1:0]  command,
	input  cond_flags_t       flags,
	input  logic              out_free,
	output ucode_t            ctrl,
	output seq_status_t       st
);

	logic             busy_q;
	logic [UPC_W-1:0] upc_q;
	logic             hit;
	logic             step;

	assign ctrl = ucode_rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			COND_NONE:    hit = 1'b0;
			COND_BAD_APP: hit = flags.bad_app;
			COND_BAD_UNL: hit = flags.bad_unl;
			COND_EMPTY:   hit = flags.empty;
		endcase
	end

	// a waiting step holds until the result register is free
	assign step = busy_q && !(ctrl.wait_out && !out_free);

	assign st.busy = busy_q;
	assign st.step = step;
	assign st.hit  = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= UA_A0;
		end else if (start) begin
			busy_q <= 1'b1;
			upc_q  <= dispatch(command);
		end else if (step) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else begin
				upc_q <= hit ? ctrl.t_addr : ctrl.f_addr;
			end
		end
	end

endmodule

FILE: rtl/core/free_block_chain_manager.sv
// channel   signals                       payload
// cmd       cmd_valid / cmd_ready         command[1:0], block[9:0]
// rsp       rsp_valid / rsp_ready         result_block[9:0], status[1:0]
//
// the result appears once the command's microprogram steps are done; cmd_ready rises
// with it; the steps serialize reads and writes on the single-port next, prev and
// flag memories
// after reset a clearing pass over all NUM_BLOCKS entries zeroes the membership flags;
// cmd_ready stays low until it ends
// a new command transfers while the previous result still waits; its first
// step holds until rsp is free, so rsp stalls never lose or repeat a result
module free_block_chain_manager import fbcm_pkg::*; #(
	parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [CMD_W-1:0]   command,
	input  logic [BLOCK_W-1:0] block,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [BLOCK_W-1:0] result_block,
	output logic [STAT_W-1:0]  status
);

	localparam int AW = $clog2(NUM_BLOCKS);
	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

	// block number is nonzero and inside the table
	function automatic logic usable(logic [BLOCK_W-1:0] b);
		return (b != '0) && (32'(b) < NUM_BLOCKS);
	endfunction

	// block number to memory address, zero-extended or truncated to AW bits
	function automatic logic [AW-1:0] to_addr(logic [BLOCK_W-1:0] b);
		logic [BLOCK_W+AW-1:0] ext;
		ext = {{AW{1'b0}}, b};
		return ext[AW-1:0];
	endfunction

	// command register
	logic [BLOCK_W-1:0] blk_q;

	// chain state
	logic [BLOCK_W-1:0] head_q;
	logic [BLOCK_W-1:0] tail_q;
	logic [BLOCK_W-1:0] target_q;
	logic [BLOCK_W-1:0] result_q;

	// flag clearing pass
	logic          clear_q;
	logic [AW-1:0] clr_cnt_q;

	// result register
	logic               rsp_valid_q;
	logic [BLOCK_W-1:0] result_block_q;
	logic [STAT_W-1:0]  status_q;

	// memory ports
	logic [AW-1:0]      next_addr, prev_addr, flag_addr;
	logic               next_we, prev_we, flag_we;
	logic [BLOCK_W-1:0] next_wd, prev_wd;
	logic               flag_wd;
	logic [BLOCK_W-1:0] next_rd, prev_rd;
	logic               flag_rd;

	// sequencer
	ucode_t      ctrl;
	seq_status_t st;
	cond_flags_t flags;
	logic        accept;
	logic        out_free;
	logic        fire;
	logic        emit;

	// succ and pred come straight off the link memories in the remove step
	logic [BLOCK_W-1:0] succ, pred;

	assign succ = next_rd;
	assign pred = prev_rd;

	assign cmd_ready = !st.busy && !clear_q;
	assign accept    = cmd_valid && cmd_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign fire      = st.step && !st.hit;
	assign emit      = st.step && ctrl.last;

	assign flags.bad_app = !usable(blk_q) || flag_rd;
	assign flags.bad_unl = !usable(blk_q) || !flag_rd;
	assign flags.empty   = !usable(head_q);

	fbcm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.command  (command),
		.flags    (flags),
		.out_free (out_free),
		.ctrl     (ctrl),
		.st       (st)
	);

	// datapath: memory port steering per microcode action
	always_comb begin
		next_addr = to_addr(blk_q);
		prev_addr = to_addr(blk_q);
		flag_addr = to_addr(blk_q);
		next_we   = 1'b0;
		prev_we   = 1'b0;
		flag_we   = 1'b0;
		next_wd   = '0;
		prev_wd   = '0;
		flag_wd   = 1'b0;
		unique case (ctrl.act)
			ACT_NONE,
			ACT_RD_FLAG,
			ACT_RD_LINKS_BLK: begin
			end
			ACT_APP_WR: begin
				// new tail entry: listed, no successor, predecessor is old tail
				flag_we = fire;
				flag_wd = 1'b1;
				next_we = fire;
				prev_we = fire;
				prev_wd = tail_q;
			end
			ACT_APP_LINK: begin
				next_addr = to_addr(tail_q);
				next_wd   = blk_q;
				next_we   = fire && (tail_q != '0);
			end
			ACT_RD_LINKS_HEAD: begin
				next_addr = to_addr(head_q);
				prev_addr = to_addr(head_q);
			end
			ACT_REMOVE: begin
				// splice neighbours around the target
				prev_addr = to_addr(succ);
				prev_wd   = pred;
				prev_we   = fire && usable(succ);
				next_addr = to_addr(pred);
				next_wd   = succ;
				next_we   = fire && usable(pred);
				flag_addr = to_addr(target_q);
				flag_we   = fire;
			end
			default: begin
			end
		endcase
		// clearing pass owns the flag memory
		if (clear_q) begin
			flag_addr = clr_cnt_q;
			flag_we   = 1'b1;
			flag_wd   = 1'b0;
		end
	end

	fbcm_ram #(.WIDTH(BLOCK_W), .DEPTH(NUM_BLOCKS)) u_next_ram (
		.clk   (clk),
		.addr  (next_addr),
		.we    (next_we),
		.wdata (next_wd),
		.rdata (next_rd)
	);

	fbcm_ram #(.WIDTH(BLOCK_W), .DEPTH(NUM_BLOCKS)) u_prev_ram (
		.clk   (clk),
		.addr  (prev_addr),
		.we    (prev_we),
		.wdata (prev_wd),
		.rdata (prev_rd)
	);

	fbcm_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_flag_ram (
		.clk   (clk),
		.addr  (flag_addr),
		.we    (flag_we),
		.wdata (flag_wd),
		.rdata (flag_rd)
	);

	// block number capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q <= block;
		end
	end

	// head, tail and work registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			target_q <= '0;
			result_q <= '0;
		end else begin
			if (accept) begin
				result_q <= '0;
			end
			if (fire) begin
				unique case (ctrl.act)
					ACT_APP_LINK: begin
						tail_q <= blk_q;
						if (tail_q == '0) begin
							head_q <= blk_q;
						end
					end
					ACT_RD_LINKS_BLK: begin
						target_q <= blk_q;
					end
					ACT_RD_LINKS_HEAD: begin
						target_q <= head_q;
						result_q <= head_q;
					end
					ACT_REMOVE: begin
						if (!usable(succ)) begin
							tail_q <= pred;
						end
						if (!usable(pred)) begin
							head_q <= succ;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// flag clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST_IDX) begin
				clear_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_block_q <= result_q;
			status_q       <= ctrl.status;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign result_block = result_block_q;
	assign status       = status_q;

	// head and tail are empty together
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == '0) == (tail_q == '0))
		else $error("head and tail disagree on empty chain");

	// a result is only written into a free result register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwrote a pending transfer");

	// a transfer starts the sequencer
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st.busy)
		else $error("sequencer not busy after command transfer");

	// memories are quiet when idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!st.busy && !clear_q) |-> !(next_we || prev_we || flag_we))
		else $error("memory write while idle");

endmodule
